/* src/kde_pkg.sv */
package kde_pkg;

  localparam int unsigned NumDigits  = 14;

  localparam logic [3:0] DIGIT_BLANK = 4'd15;
  localparam logic [2:0] FIELD_NONE  = 3'd6;
  localparam logic [2:0] FIELD_LAST  = 3'd5;

  typedef enum logic [2:0] {
    REQ_OPEN   = 3'd0,
    REQ_SELECT = 3'd1,
    REQ_KEY    = 3'd2,
    REQ_READ   = 3'd3,
    REQ_WRITE  = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    MSG_NONE         = 3'd0,
    MSG_UNAVAILABLE  = 3'd1,
    MSG_SELECT_FIELD = 3'd2,
    MSG_INCOMPLETE   = 3'd3,
    MSG_BAD_DATE     = 3'd4,
    MSG_BAD_TIME     = 3'd5,
    MSG_SAVING       = 3'd6,
    MSG_WRITE_FAILED = 3'd7
  } msg_e;

  typedef enum logic [1:0] {
    KEY_DIGIT,
    KEY_SAVE,
    KEY_BACK,
    KEY_IGNORED
  } key_kind_e;

  typedef struct packed {
    key_kind_e  kind;
    logic [3:0] digit;
  } key_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digit_pair_t;

  // keypad layout 7 8 9 / 4 5 6 / 1 2 3 / save 0 backspace
  function automatic key_t key_decode(input logic [3:0] key);
    key_t k;
    k.kind  = KEY_DIGIT;
    k.digit = 4'd0;
    unique case (key)
      4'd0:    k.digit = 4'd7;
      4'd1:    k.digit = 4'd8;
      4'd2:    k.digit = 4'd9;
      4'd3:    k.digit = 4'd4;
      4'd4:    k.digit = 4'd5;
      4'd5:    k.digit = 4'd6;
      4'd6:    k.digit = 4'd1;
      4'd7:    k.digit = 4'd2;
      4'd8:    k.digit = 4'd3;
      4'd9:    k.kind  = KEY_SAVE;
      4'd10:   k.digit = 4'd0;
      4'd11:   k.kind  = KEY_BACK;
      default: k.kind  = KEY_IGNORED;
    endcase
    return k;
  endfunction

  // field that owns buffer position i (YYYYMMDDhhmmss)
  function automatic logic [2:0] field_of(input int unsigned i);
    logic [2:0] f;
    if (i < 4) begin
      f = 3'd0;
    end else begin
      f = 3'((((i - 4) >> 1) + 1));
    end
    return f;
  endfunction

  // position of buffer digit i inside its field
  function automatic logic [1:0] pos_of(input int unsigned i);
    logic [1:0] p;
    if (i < 4) begin
      p = 2'(i);
    end else begin
      p = {1'b0, 1'(i - 4)};
    end
    return p;
  endfunction

  function automatic logic [2:0] field_len(input logic [2:0] f);
    return (f == 3'd0) ? 3'd4 : 3'd2;
  endfunction

  // value / 10 as (v * 205) >> 11, exact over seven bits
  function automatic digit_pair_t split2(input logic [6:0] v);
    logic [14:0]  prod;
    logic [6:0]   rem;
    digit_pair_t  r;
    prod   = 15'(v) * 15'd205;
    r.tens = prod[14:11];
    rem    = v - 7'(r.tens * 4'd10);
    r.ones = rem[3:0];
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] d;
    unique case (mo)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* src/keypad_datetime_entry_unit.sv */
// channel | direction | handshake             | payload
// in      | into unit | in_valid_i/in_stall_o | req_type, field_index, key_pos,
//         |           |                       | clock_success, read_year..read_second
// out     | from unit | out_valid_o/out_stall_i| message_code, current_field, read/write
//         |           |                       | requests, write_year..write_second, session_done
//
// one word in and one word out per cycle sustained while the output does not stall
// first the decimal split of the clock read date-time goes into the input register,
// then key, select and save checks update the editor state and load the output register
// reset clears the state to an empty buffer with no field selected and no clock
// a stalled output holds; the input register keeps taking words while the output has room

module keypad_datetime_entry_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [2:0]  field_index_i,
  input  logic [3:0]  key_pos_i,
  input  logic        clock_success_i,
  input  logic [13:0] read_year_i,
  input  logic [6:0]  read_month_i,
  input  logic [6:0]  read_day_i,
  input  logic [6:0]  read_hour_i,
  input  logic [6:0]  read_minute_i,
  input  logic [6:0]  read_second_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  message_code_o,
  output logic [2:0]  current_field_o,
  output logic        read_request_o,
  output logic        write_request_o,
  output logic [11:0] write_year_o,
  output logic [3:0]  write_month_o,
  output logic [4:0]  write_day_o,
  output logic [4:0]  write_hour_o,
  output logic [5:0]  write_minute_o,
  output logic [5:0]  write_second_o,
  output logic        session_done_o
);
  import kde_pkg::*;

  // ---------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_take;
  logic proc;

  // the held word is processed when the output register is free or draining
  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // stage one: split the clock read into decimal digits
  // ---------------------------------------------------------------------
  logic [13:0] year_mod;
  logic [30:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;
  logic [9:0]  yq10;
  logic [6:0]  yq100;
  logic [3:0]  yq1000;
  logic [13:0] yrem3;
  logic [9:0]  yrem2;
  logic [6:0]  yrem1;
  logic [3:0]  rd_digit [NumDigits];
  digit_pair_t mo_split, dy_split, hr_split, mi_split, se_split;

  // year is taken mod 10000, one subtract is enough for 14 bits
  assign year_mod = (read_year_i >= 14'd10000) ? (read_year_i - 14'd10000) : read_year_i;

  // quotients by 10, 100 and 1000 through reciprocal multiplies, all from year_mod
  assign prod10   = 31'(year_mod) * 31'd52429;
  assign prod100  = 27'(year_mod) * 27'd5243;
  assign prod1000 = 28'(year_mod) * 28'd8389;
  assign yq10     = prod10[28:19];
  assign yq100    = prod100[25:19];
  assign yq1000   = prod1000[26:23];

  assign yrem3 = year_mod - 14'(yq10 * 4'd10);
  assign yrem2 = yq10 - 10'(yq100 * 4'd10);
  assign yrem1 = yq100 - 7'(yq1000 * 4'd10);

  assign mo_split = split2(read_month_i);
  assign dy_split = split2(read_day_i);
  assign hr_split = split2(read_hour_i);
  assign mi_split = split2(read_minute_i);
  assign se_split = split2(read_second_i);

  always_comb begin
    rd_digit[0]  = yq1000;
    rd_digit[1]  = yrem1[3:0];
    rd_digit[2]  = yrem2[3:0];
    rd_digit[3]  = yrem3[3:0];
    rd_digit[4]  = mo_split.tens;
    rd_digit[5]  = mo_split.ones;
    rd_digit[6]  = dy_split.tens;
    rd_digit[7]  = dy_split.ones;
    rd_digit[8]  = hr_split.tens;
    rd_digit[9]  = hr_split.ones;
    rd_digit[10] = mi_split.tens;
    rd_digit[11] = mi_split.ones;
    rd_digit[12] = se_split.tens;
    rd_digit[13] = se_split.ones;
  end

  // input register, payload only
  logic [2:0] req_q;
  logic [2:0] fld_q;
  logic [3:0] key_q;
  logic       ok_q;
  logic [3:0] rd_q [NumDigits];

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= req_type_i;
      fld_q <= field_index_i;
      key_q <= key_pos_i;
      ok_q  <= clock_success_i;
      rd_q  <= rd_digit;
    end
  end

  // ---------------------------------------------------------------------
  // editor state
  // ---------------------------------------------------------------------
  logic [3:0] buf_q [NumDigits];
  logic [3:0] buf_d [NumDigits];
  logic [2:0] sel_q, sel_d;
  logic [2:0] off_q, off_d;
  logic       started_q, started_d;
  logic       loading_q, loading_d;
  logic       saving_q, saving_d;
  logic       avail_q, avail_d;
  msg_e       msg_q, msg_d;

  // ---------------------------------------------------------------------
  // save checks, always evaluated on the current buffer
  // ---------------------------------------------------------------------
  logic        complete;
  logic [13:0] num_year;
  logic [7:0]  num_month, num_day, num_hour, num_minute, num_second;
  logic        leap;
  logic [4:0]  dim;
  logic        date_ok, time_ok;

  always_comb begin
    complete = 1'b1;
    for (int unsigned i = 0; i < NumDigits; i++) begin
      if (buf_q[i] == DIGIT_BLANK) begin
        complete = 1'b0;
      end
    end
  end

  assign num_year   = 14'(buf_q[0]) * 14'd1000 + 14'(buf_q[1]) * 14'd100
                    + 14'(buf_q[2]) * 14'd10 + 14'(buf_q[3]);
  assign num_month  = 8'(buf_q[4]) * 8'd10 + 8'(buf_q[5]);
  assign num_day    = 8'(buf_q[6]) * 8'd10 + 8'(buf_q[7]);
  assign num_hour   = 8'(buf_q[8]) * 8'd10 + 8'(buf_q[9]);
  assign num_minute = 8'(buf_q[10]) * 8'd10 + 8'(buf_q[11]);
  assign num_second = 8'(buf_q[12]) * 8'd10 + 8'(buf_q[13]);

  // within 2000..2099 the only century year is 2000, which is divisible by 400,
  // so divisibility by four alone gives the gregorian rule there
  assign leap = (num_year[1:0] == 2'b00);
  assign dim  = month_days(num_month[3:0], leap);

  assign date_ok = (num_year >= 14'd2000) && (num_year <= 14'd2099)
                && (num_month >= 8'd1) && (num_month <= 8'd12)
                && (num_day >= 8'd1) && (num_day <= 8'(dim));
  assign time_ok = (num_hour <= 8'd23) && (num_minute <= 8'd59) && (num_second <= 8'd59);

  // ---------------------------------------------------------------------
  // stage two: next editor state and result word
  // ---------------------------------------------------------------------
  key_t       key;
  logic [2:0] eff_off;
  logic [2:0] off_inc;
  logic       rd_req, wr_req, done;

  assign key     = key_decode(key_q);
  // a fresh entry restarts at the first digit of the field
  assign eff_off = started_q ? off_q : 3'd0;
  assign off_inc = eff_off + 3'd1;

  always_comb begin
    buf_d     = buf_q;
    sel_d     = sel_q;
    off_d     = off_q;
    started_d = started_q;
    loading_d = loading_q;
    saving_d  = saving_q;
    avail_d   = avail_q;
    msg_d     = msg_q;
    rd_req    = 1'b0;
    wr_req    = 1'b0;
    done      = 1'b0;
    unique case (req_q)
      REQ_OPEN: begin
        for (int unsigned i = 0; i < NumDigits; i++) begin
          buf_d[i] = DIGIT_BLANK;
        end
        sel_d     = FIELD_NONE;
        off_d     = 3'd0;
        started_d = 1'b0;
        loading_d = 1'b1;
        saving_d  = 1'b0;
        avail_d   = 1'b0;
        msg_d     = MSG_NONE;
        rd_req    = 1'b1;
      end
      REQ_SELECT: begin
        if (fld_q <= FIELD_LAST) begin
          sel_d     = fld_q;
          off_d     = 3'd0;
          started_d = 1'b0;
          msg_d     = avail_q ? MSG_NONE : MSG_UNAVAILABLE;
        end
      end
      REQ_KEY: begin
        // keys count only with the clock up and no load or save pending
        if (key.kind != KEY_IGNORED && avail_q && !loading_q && !saving_q) begin
          priority if (key.kind == KEY_SAVE) begin
            priority if (!complete) begin
              msg_d = MSG_INCOMPLETE;
            end else if (!date_ok) begin
              msg_d = MSG_BAD_DATE;
            end else if (!time_ok) begin
              msg_d = MSG_BAD_TIME;
            end else begin
              saving_d = 1'b1;
              msg_d    = MSG_SAVING;
              wr_req   = 1'b1;
            end
          end else if (sel_q > FIELD_LAST) begin
            msg_d = MSG_SELECT_FIELD;
          end else if (key.kind == KEY_BACK) begin
            for (int unsigned i = 0; i < NumDigits; i++) begin
              if (field_of(i) == sel_q) begin
                buf_d[i] = DIGIT_BLANK;
              end
            end
            off_d     = 3'd0;
            started_d = 1'b1;
            msg_d     = MSG_NONE;
          end else begin
            // digit: write at the entry offset, blank the rest on a fresh entry
            for (int unsigned i = 0; i < NumDigits; i++) begin
              if (field_of(i) == sel_q) begin
                if ({1'b0, pos_of(i)} == eff_off) begin
                  buf_d[i] = key.digit;
                end else if (!started_q) begin
                  buf_d[i] = DIGIT_BLANK;
                end
              end
            end
            msg_d = MSG_NONE;
            if (off_inc >= field_len(sel_q)) begin
              // field full, move to the next one
              sel_d     = sel_q + 3'd1;
              off_d     = 3'd0;
              started_d = 1'b0;
            end else begin
              off_d     = off_inc;
              started_d = 1'b1;
            end
          end
        end
      end
      REQ_READ: begin
        loading_d = 1'b0;
        avail_d   = ok_q;
        if (ok_q) begin
          buf_d = rd_q;
          msg_d = MSG_NONE;
        end else begin
          msg_d = MSG_UNAVAILABLE;
        end
      end
      REQ_WRITE: begin
        saving_d = 1'b0;
        if (ok_q) begin
          done = 1'b1;
        end else begin
          msg_d = MSG_WRITE_FAILED;
        end
      end
      default: begin
        // unknown request codes leave everything as it is
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int unsigned i = 0; i < NumDigits; i++) begin
        buf_q[i] <= DIGIT_BLANK;
      end
      sel_q     <= FIELD_NONE;
      off_q     <= 3'd0;
      started_q <= 1'b0;
      loading_q <= 1'b0;
      saving_q  <= 1'b0;
      avail_q   <= 1'b0;
      msg_q     <= MSG_NONE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        buf_q     <= buf_d;
        sel_q     <= sel_d;
        off_q     <= off_d;
        started_q <= started_d;
        loading_q <= loading_d;
        saving_q  <= saving_d;
        avail_q   <= avail_d;
        msg_q     <= msg_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register, payload only
  // ---------------------------------------------------------------------
  logic [2:0]  res_msg_q;
  logic [2:0]  res_field_q;
  logic        res_rd_q, res_wr_q, res_done_q;
  logic [11:0] res_year_q;
  logic [3:0]  res_month_q;
  logic [4:0]  res_day_q;
  logic [4:0]  res_hour_q;
  logic [5:0]  res_minute_q;
  logic [5:0]  res_second_q;

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_msg_q    <= msg_d;
      res_field_q  <= sel_d;
      res_rd_q     <= rd_req;
      res_wr_q     <= wr_req;
      res_done_q   <= done;
      res_year_q   <= wr_req ? num_year[11:0] : 12'd2000;
      res_month_q  <= wr_req ? num_month[3:0] : 4'd0;
      res_day_q    <= wr_req ? num_day[4:0] : 5'd0;
      res_hour_q   <= wr_req ? num_hour[4:0] : 5'd0;
      res_minute_q <= wr_req ? num_minute[5:0] : 6'd0;
      res_second_q <= wr_req ? num_second[5:0] : 6'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign message_code_o  = res_msg_q;
  assign current_field_o = res_field_q;
  assign read_request_o  = res_rd_q;
  assign write_request_o = res_wr_q;
  assign write_year_o    = res_year_q;
  assign write_month_o   = res_month_q;
  assign write_day_o     = res_day_q;
  assign write_hour_o    = res_hour_q;
  assign write_minute_o  = res_minute_q;
  assign write_second_o  = res_second_q;
  assign session_done_o  = res_done_q;

endmodule

/* src/kde_checker.sv */
module kde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  message_code_o,
  input logic [2:0]  current_field_o,
  input logic        read_request_o,
  input logic        write_request_o,
  input logic [11:0] write_year_o,
  input logic [3:0]  write_month_o,
  input logic [4:0]  write_day_o,
  input logic        session_done_o
);
  import kde_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(message_code_o)
      && $stable(write_request_o))
    else $error("stalled output word changed");

  // the input backs up only behind a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room at the output");

  // a write goes out only together with the saving message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_request_o |-> message_code_o == MSG_SAVING
      && !read_request_o && !session_done_o)
    else $error("write request without saving message");

  // no write means default write fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_request_o |-> write_year_o == 12'd2000
      && write_month_o == 4'd0 && write_day_o == 5'd0)
    else $error("write fields set without a write");

  // opening a session always shows a cleared editor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_request_o |-> message_code_o == MSG_NONE
      && current_field_o == FIELD_NONE)
    else $error("session open did not clear the editor");

endmodule

bind keypad_datetime_entry_unit kde_checker u_kde_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .message_code_o  (message_code_o),
  .current_field_o (current_field_o),
  .read_request_o  (read_request_o),
  .write_request_o (write_request_o),
  .write_year_o    (write_year_o),
  .write_month_o   (write_month_o),
  .write_day_o     (write_day_o),
  .session_done_o  (session_done_o)
);

/* sim/kde_entry_check_pkg.sv */
`timescale 1ns / 1ps

package kde_entry_check_pkg;
  import kde_pkg::*;

  localparam logic [3:0] KEYPAD_SAVE    = 4'd9;
  localparam logic [3:0] KEYPAD_BACK    = 4'd11;
  localparam logic [3:0] KEYPAD_IGNORED = 4'd14;
  localparam int unsigned KEYPAD_KEYS   = 12;
  localparam logic [2:0] REQ_UNKNOWN    = 3'd6;
  localparam logic [2:0] FIELD_BAD      = 3'd7;

  typedef struct packed {
    logic [2:0]  req;
    logic [2:0]  fld;
    logic [3:0]  key;
    logic        ok;
    logic [13:0] yr;
    logic [6:0]  mo;
    logic [6:0]  dy;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
  } entry_word_t;

  typedef struct packed {
    msg_e        msg;
    logic [2:0]  field;
    logic        rd;
    logic        wr;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
    logic        done;
  } reply_t;

  // keypad position to digit, 7 8 9 / 4 5 6 / 1 2 3 / - 0 -
  function automatic logic [3:0] keypad_digit(input logic [3:0] k);
    case (k)
      4'd0: return 4'd7;
      4'd1: return 4'd8;
      4'd2: return 4'd9;
      4'd3: return 4'd4;
      4'd4: return 4'd5;
      4'd5: return 4'd6;
      4'd6: return 4'd1;
      4'd7: return 4'd2;
      4'd8: return 4'd3;
      default: return 4'd0;
    endcase
  endfunction

  // digit to keypad position
  function automatic logic [3:0] digit_key(input logic [3:0] d);
    case (d)
      4'd1: return 4'd6;
      4'd2: return 4'd7;
      4'd3: return 4'd8;
      4'd4: return 4'd3;
      4'd5: return 4'd4;
      4'd6: return 4'd5;
      4'd7: return 4'd0;
      4'd8: return 4'd1;
      4'd9: return 4'd2;
      default: return 4'd10;
    endcase
  endfunction

  class entry_tracker;
    logic [3:0] digits [NumDigits];
    logic [2:0] sel_field;
    logic [2:0] offset;
    bit         started;
    bit         loading;
    bit         saving;
    bit         avail;
    msg_e       msg;
    reply_t     expected_replies [$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_writes;
    int unsigned n_done;

    function new();
      clear();
      errors    = 0;
      n_checked = 0;
      n_writes  = 0;
      n_done    = 0;
    endfunction

    function void clear();
      foreach (digits[i]) digits[i] = DIGIT_BLANK;
      sel_field = FIELD_NONE;
      offset    = 3'd0;
      started   = 1'b0;
      loading   = 1'b0;
      saving    = 1'b0;
      avail     = 1'b0;
      msg       = MSG_NONE;
    endfunction

    function int unsigned field_base(input int unsigned f);
      return (f == 0) ? 0 : 2 * f + 2;
    endfunction

    function int unsigned field_width(input int unsigned f);
      return (f == 0) ? 4 : 2;
    endfunction

    function void blank(input int unsigned f);
      for (int unsigned i = 0; i < field_width(f); i++) digits[field_base(f) + i] = DIGIT_BLANK;
    endfunction

    function void split_into(input int unsigned pos, input logic [6:0] v);
      digits[pos]     = 4'(v / 10);
      digits[pos + 1] = 4'(v % 10);
    endfunction

    function void type_digit(input logic [3:0] d);
      int unsigned f;
      f = sel_field;
      if (f > FIELD_LAST) begin
        msg = MSG_SELECT_FIELD;
        return;
      end
      if (!started) begin
        blank(f);
        offset  = 3'd0;
        started = 1'b1;
      end
      if (offset < field_width(f)) digits[field_base(f) + offset] = d;
      offset = offset + 3'd1;
      msg    = MSG_NONE;
      if (offset >= field_width(f)) begin
        sel_field = 3'(f + 1);
        offset    = 3'd0;
        started   = 1'b0;
      end
    endfunction

    function void erase_field();
      if (sel_field > FIELD_LAST) begin
        msg = MSG_SELECT_FIELD;
        return;
      end
      blank(sel_field);
      offset  = 3'd0;
      started = 1'b1;
      msg     = MSG_NONE;
    endfunction

    function void try_commit(inout reply_t r);
      int unsigned y, mo, dy, hr, mi, se, lim;
      bit leap;
      foreach (digits[i]) begin
        if (digits[i] == DIGIT_BLANK) begin
          msg = MSG_INCOMPLETE;
          return;
        end
      end
      y  = 1000 * digits[0] + 100 * digits[1] + 10 * digits[2] + digits[3];
      mo = 10 * digits[4] + digits[5];
      dy = 10 * digits[6] + digits[7];
      hr = 10 * digits[8] + digits[9];
      mi = 10 * digits[10] + digits[11];
      se = 10 * digits[12] + digits[13];
      if (y < 2000 || y > 2099 || mo < 1 || mo > 12 || dy < 1) begin
        msg = MSG_BAD_DATE;
        return;
      end
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (mo)
        2:           lim = leap ? 29 : 28;
        4, 6, 9, 11: lim = 30;
        default:     lim = 31;
      endcase
      if (dy > lim) begin
        msg = MSG_BAD_DATE;
        return;
      end
      if (hr > 23 || mi > 59 || se > 59) begin
        msg = MSG_BAD_TIME;
        return;
      end
      saving = 1'b1;
      msg    = MSG_SAVING;
      r.wr   = 1'b1;
      r.yr   = 12'(y);
      r.mo   = 4'(mo);
      r.dy   = 5'(dy);
      r.hr   = 5'(hr);
      r.mi   = 6'(mi);
      r.se   = 6'(se);
    endfunction

    // advance the editor by one accepted word and queue the reply it causes
    function void note_word(input entry_word_t w);
      reply_t r;
      int unsigned y;
      r    = '0;
      r.yr = 12'd2000;
      case (w.req)
        REQ_OPEN: begin
          clear();
          loading = 1'b1;
          r.rd    = 1'b1;
        end
        REQ_SELECT: begin
          if (w.fld <= FIELD_LAST) begin
            sel_field = w.fld;
            offset    = 3'd0;
            started   = 1'b0;
            msg       = avail ? MSG_NONE : MSG_UNAVAILABLE;
          end
        end
        REQ_KEY: begin
          if (w.key < KEYPAD_KEYS && avail && !loading && !saving) begin
            if (w.key == KEYPAD_SAVE) try_commit(r);
            else if (w.key == KEYPAD_BACK) erase_field();
            else type_digit(keypad_digit(w.key));
          end
        end
        REQ_READ: begin
          loading = 1'b0;
          avail   = w.ok;
          if (w.ok) begin
            y         = w.yr % 10000;
            digits[0] = 4'(y / 1000);
            digits[1] = 4'(y / 100 % 10);
            digits[2] = 4'(y / 10 % 10);
            digits[3] = 4'(y % 10);
            split_into(4, w.mo);
            split_into(6, w.dy);
            split_into(8, w.hr);
            split_into(10, w.mi);
            split_into(12, w.se);
            msg = MSG_NONE;
          end else begin
            msg = MSG_UNAVAILABLE;
          end
        end
        REQ_WRITE: begin
          saving = 1'b0;
          if (w.ok) r.done = 1'b1;
          else msg = MSG_WRITE_FAILED;
        end
        default: ;
      endcase
      r.msg   = msg;
      r.field = sel_field;
      expected_replies.push_back(r);
    endfunction

    function void match_field(input string name, input int unsigned want, input int unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_result(input reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with no word outstanding, message_code actual %0d",
                 $time, got.msg);
        return;
      end
      want = expected_replies.pop_front();
      n_checked++;
      if (want.wr) n_writes++;
      if (want.done) n_done++;
      match_field("message_code", want.msg, got.msg);
      match_field("current_field", want.field, got.field);
      match_field("read_request", want.rd, got.rd);
      match_field("write_request", want.wr, got.wr);
      match_field("write_year", want.yr, got.yr);
      match_field("write_month", want.mo, got.mo);
      match_field("write_day", want.dy, got.dy);
      match_field("write_hour", want.hr, got.hr);
      match_field("write_minute", want.mi, got.mi);
      match_field("write_second", want.se, got.se);
      match_field("session_done", want.done, got.done);
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

endpackage

/* sim/tb_keypad_datetime_entry_unit.sv */
`timescale 1ns / 1ps

module tb_keypad_datetime_entry_unit;
  import kde_pkg::*;
  import kde_entry_check_pkg::*;

  localparam int unsigned WORD_TARGET  = 1150;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall_o;
  entry_word_t in_word;
  logic        out_valid_o;
  logic        out_stall;
  logic [2:0]  message_code_o;
  logic [2:0]  current_field_o;
  logic        read_request_o;
  logic        write_request_o;
  logic [11:0] write_year_o;
  logic [3:0]  write_month_o;
  logic [4:0]  write_day_o;
  logic [4:0]  write_hour_o;
  logic [5:0]  write_minute_o;
  logic [5:0]  write_second_o;
  logic        session_done_o;

  entry_tracker tracker;
  int unsigned  words_sent = 0;
  int unsigned  cycles = 0;
  bit           send_quiet = 1'b0;   // sender offers back to back while set
  bit           recv_quiet = 1'b0;   // receiver adds no random stall while set
  bit           hold_req = 1'b0;     // asks the receiver for one long stall
  bit           hold_seen = 1'b0;
  bit           drain_seen = 1'b0;

  keypad_datetime_entry_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .req_type_i      (in_word.req),
    .field_index_i   (in_word.fld),
    .key_pos_i       (in_word.key),
    .clock_success_i (in_word.ok),
    .read_year_i     (in_word.yr),
    .read_month_i    (in_word.mo),
    .read_day_i      (in_word.dy),
    .read_hour_i     (in_word.hr),
    .read_minute_i   (in_word.mi),
    .read_second_i   (in_word.se),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .message_code_o  (message_code_o),
    .current_field_o (current_field_o),
    .read_request_o  (read_request_o),
    .write_request_o (write_request_o),
    .write_year_o    (write_year_o),
    .write_month_o   (write_month_o),
    .write_day_o     (write_day_o),
    .write_hour_o    (write_hour_o),
    .write_minute_o  (write_minute_o),
    .write_second_o  (write_second_o),
    .session_done_o  (session_done_o)
  );

  always #10 clk_i = ~clk_i;

  // watchdog on a hung handshake
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // both handshakes seen at the edge; an accepted word feeds the predictor,
  // an accepted reply is checked against the oldest prediction
  always @(posedge clk_i) begin
    reply_t got;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) tracker.note_word(in_word);
      if (out_valid_o && !out_stall) begin
        got.msg   = msg_e'(message_code_o);
        got.field = current_field_o;
        got.rd    = read_request_o;
        got.wr    = write_request_o;
        got.yr    = write_year_o;
        got.mo    = write_month_o;
        got.dy    = write_day_o;
        got.hr    = write_hour_o;
        got.mi    = write_minute_o;
        got.se    = write_second_o;
        got.done  = session_done_o;
        tracker.check_result(got);
      end
    end
  end

  // reply side: random stall before each reply, quiet stretches, one long hold
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        // output stays blocked while the sender keeps offering, so the unit fills up
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
        n = recv_quiet ? 0 : $urandom_range(0, 12);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one word on the input channel; returns at the edge that took it
  task automatic send_word(input entry_word_t w);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // every field random, so unused fields toggle too
  function automatic entry_word_t filler();
    entry_word_t w;
    w.req = 3'($urandom);
    w.fld = 3'($urandom);
    w.key = 4'($urandom);
    w.ok  = 1'($urandom);
    w.yr  = 14'($urandom);
    w.mo  = 7'($urandom);
    w.dy  = 7'($urandom);
    w.hr  = 7'($urandom);
    w.mi  = 7'($urandom);
    w.se  = 7'($urandom);
    return w;
  endfunction

  task automatic do_open();
    entry_word_t w;
    w     = filler();
    w.req = REQ_OPEN;
    send_word(w);
  endtask

  task automatic do_select(input logic [2:0] f);
    entry_word_t w;
    w     = filler();
    w.req = REQ_SELECT;
    w.fld = f;
    send_word(w);
  endtask

  task automatic do_key(input logic [3:0] k);
    entry_word_t w;
    w     = filler();
    w.req = REQ_KEY;
    w.key = k;
    send_word(w);
  endtask

  task automatic do_read(input logic ok, input logic [13:0] y, input logic [6:0] mo,
                         input logic [6:0] dy, input logic [6:0] hr, input logic [6:0] mi,
                         input logic [6:0] se);
    entry_word_t w;
    w     = filler();
    w.req = REQ_READ;
    w.ok  = ok;
    w.yr  = y;
    w.mo  = mo;
    w.dy  = dy;
    w.hr  = hr;
    w.mi  = mi;
    w.se  = se;
    send_word(w);
  endtask

  task automatic do_write(input logic ok);
    entry_word_t w;
    w     = filler();
    w.req = REQ_WRITE;
    w.ok  = ok;
    send_word(w);
  endtask

  // select a field and key in its decimal digits, most significant first
  task automatic type_value(input int unsigned f, input int unsigned value);
    int unsigned scale;
    do_select(3'(f));
    scale = (f == 0) ? 1000 : 10;
    while (scale != 0) begin
      do_key(digit_key(4'((value / scale) % 10)));
      scale = scale / 10;
    end
  endtask

  // pause the sender until every reply is back; the first edge lets the
  // monitor note the last accepted word
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed editing sessions: open, clock read, entry, save, write result
  task automatic run_session();
    int unsigned yr, mo, dy, hr, mi, se, f;
    do_open();
    if ($urandom_range(0, 9) == 0) do_key(4'($urandom_range(0, 11)));
    case ($urandom_range(0, 7))
      0: do_read(1'b0, 14'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                 7'($urandom), 7'($urandom));
      1, 2: do_read(1'b1, 14'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                    7'($urandom), 7'($urandom));
      default: do_read(1'b1, 14'($urandom_range(1995, 2104)), 7'($urandom_range(0, 13)),
                       7'($urandom_range(0, 32)), 7'($urandom_range(0, 24)),
                       7'($urandom_range(0, 60)), 7'($urandom_range(0, 60)));
    endcase
    if ($urandom_range(0, 1) == 1) begin
      // whole date-time typed in, mostly in range
      yr = ($urandom_range(0, 9) == 0) ? $urandom_range(1900, 2199) : $urandom_range(2000, 2099);
      mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      dy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
      if ($urandom_range(0, 5) == 0) begin
        // end of february around the leap rule
        mo = 2;
        dy = $urandom_range(28, 30);
      end
      hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
      mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
      se = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
      type_value(0, yr);
      type_value(1, mo);
      type_value(2, dy);
      type_value(3, hr);
      type_value(4, mi);
      type_value(5, se);
    end
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 7))
        0, 1: begin
          f = $urandom_range(0, 5);
          type_value(f, $urandom_range(0, (f == 0) ? 9999 : 99));
        end
        2: begin
          // partial entry, the next key continues in the same field
          do_select(3'($urandom_range(0, 5)));
          do_key(digit_key(4'($urandom_range(0, 9))));
        end
        3: do_key(KEYPAD_BACK);
        4: do_key(digit_key(4'($urandom_range(0, 9))));
        5: do_select(3'($urandom));
        6: do_key(KEYPAD_SAVE);
        default: do_key(4'($urandom));
      endcase
    end
    do_key(KEYPAD_SAVE);
    if ($urandom_range(0, 4) == 0) do_key(KEYPAD_SAVE);
    do_write($urandom_range(0, 3) != 0);
  endtask

  initial begin
    entry_word_t w;
    tracker = new();
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: blocked and ignored words, bad buffers, save and write outcomes
    do_key(4'd0);                          // clock never read, key blocked
    do_select(3'd0);                       // select while clock unavailable
    w     = filler();
    w.req = REQ_UNKNOWN;
    send_word(w);
    do_open();
    do_key(digit_key(4'd5));               // read still pending
    do_read(1'b0, '1, '1, '1, '1, '1, '1); // clock read fails
    do_read(1'b1, '1, '1, '1, '1, '1, '1); // tens digits above nine
    do_key(digit_key(4'd3));               // no field selected
    do_key(KEYPAD_BACK);
    do_key(KEYPAD_IGNORED);
    do_select(FIELD_BAD);
    do_key(KEYPAD_SAVE);                   // year out of range
    type_value(0, 2024);
    do_key(KEYPAD_BACK);                   // month blanked
    do_key(KEYPAD_SAVE);                   // incomplete buffer
    do_read(1'b1, 14'd2024, 7'd2, 7'd29, 7'd24, 7'd0, 7'd0);
    do_key(KEYPAD_SAVE);                   // hour out of range
    do_read(1'b1, 14'd2000, 7'd2, 7'd29, 7'd23, 7'd59, 7'd59);
    do_key(KEYPAD_SAVE);                   // century leap year, write issued
    do_key(digit_key(4'd1));               // blocked while saving
    do_write(1'b0);
    do_key(KEYPAD_SAVE);
    do_write(1'b1);

    // random sessions with bursts of noise words in between
    while (words_sent < WORD_TARGET) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      if (!hold_seen && words_sent > 300) begin
        hold_seen  = 1'b1;
        hold_req   = 1'b1;
        send_quiet = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) send_word(filler());
      end else begin
        run_session();
      end
      if (!drain_seen && words_sent > 700) begin
        drain_seen = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d words, checked %0d replies: %0d writes issued, %0d sessions done",
             words_sent, tracker.n_checked, tracker.n_writes, tracker.n_done);
    $display("included a %0d-cycle output hold and a full drain mid-run", HOLD_CYCLES);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/kde_pkg.sv
src/keypad_datetime_entry_unit.sv
src/kde_checker.sv
sim/kde_entry_check_pkg.sv
sim/tb_keypad_datetime_entry_unit.sv
